### hdl/itp_pkg.sv
// Shared types and constants for the isometric tile projection block.
package itp_pkg;

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_TILE   = 2'd0;
    localparam logic [1:0] FUNC_FINE   = 2'd1;
    localparam logic [1:0] FUNC_SCREEN = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM          = 3'd5;

    // Zoom scaling: tile steps are 8/16/32 by 4/8/16, height steps 5/10/20.
    localparam logic [1:0] ZOOM_MAX     = 2'd2;
    localparam logic [2:0] STEP_X_SHIFT = 3'd3;
    localparam logic [2:0] STEP_Y_SHIFT = 3'd2;
    localparam int         LIFT_BASE    = 5;
    // Fine coordinates are in 1/256 tile.
    localparam logic [3:0] FINE_SHIFT   = 4'd8;

    // Reset values of the screen size and view registers.
    localparam logic [11:0] SCREEN_WIDTH_RESET  = 12'd640;
    localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd480;
    localparam logic [1:0]  ROTATION_RESET      = 2'd0;
    localparam logic [1:0]  ZOOM_RESET          = 2'd1;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [19:0] coord_a;
        logic signed [19:0] coord_b;
        logic signed [15:0] height;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_a;
        logic signed [31:0] out_b;
        logic signed [31:0] depth_key;
    } t_out_item;

    typedef struct packed {
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [8:0]  camera_x;
        logic [8:0]  camera_y;
        logic [1:0]  rotation;
        logic [1:0]  zoom;
    } t_cfg;

endpackage

### hdl/itp_core.sv
// Combinational projection datapath: one item in, one result out.
module itp_core
    import itp_pkg::*;
(
    input  t_cfg      i_cfg,
    input  t_in_item  i_item,
    output t_out_item o_item
);

    // Arithmetic right shift that truncates toward zero like a C division.
    function automatic logic signed [31:0] trunc_shr(input logic signed [31:0] x,
                                                     input logic [3:0] sh);
        logic signed [31:0] bias;
        bias = x[31] ? ((32'sd1 <<< sh) - 32'sd1) : 32'sd0;
        return (x + bias) >>> sh;
    endfunction

    logic [1:0]         z;
    logic [2:0]         xsh;
    logic [2:0]         ysh;
    logic               neg;
    logic signed [19:0] a_s;
    logic signed [19:0] b_s;
    logic signed [15:0] h_s;
    logic [17:0]        base_x;
    logic [17:0]        base_y;
    logic signed [20:0] dx;
    logic signed [20:0] dy;
    logic signed [21:0] u;
    logic signed [21:0] v;
    logic signed [22:0] um1;
    logic signed [27:0] px_full;
    logic signed [25:0] py_full;
    logic signed [18:0] h5;
    logic signed [20:0] hg;
    logic signed [31:0] cw;
    logic signed [31:0] ch;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] pxs;
    logic signed [31:0] pys;
    logic signed [31:0] hs;
    logic signed [31:0] sv;
    logic signed [31:0] t1;
    logic signed [31:0] t2;
    logic signed [31:0] t3;
    logic signed [31:0] tt;
    logic signed [31:0] ra;
    logic signed [31:0] rb;
    logic               fine;

    always_comb begin
        z    = (i_cfg.zoom > ZOOM_MAX) ? ZOOM_MAX : i_cfg.zoom;
        xsh  = STEP_X_SHIFT + 3'(z);
        ysh  = STEP_Y_SHIFT + 3'(z);
        neg  = i_cfg.rotation[1];
        fine = (i_item.func == FUNC_FINE);
        a_s  = i_item.coord_a;
        b_s  = i_item.coord_b;
        h_s  = i_item.height;
        cw   = 32'(i_cfg.screen_width >> 1);
        ch   = 32'(i_cfg.screen_height >> 1);
        cx   = 32'(i_cfg.camera_x);
        cy   = 32'(i_cfg.camera_y);

        // Offset from the camera tile, in tile or fine units.
        base_x = fine ? {1'b0, i_cfg.camera_x, 8'd0} : {9'd0, i_cfg.camera_x};
        base_y = fine ? {1'b0, i_cfg.camera_y, 8'd0} : {9'd0, i_cfg.camera_y};
        dx = 21'(a_s) - 21'({3'd0, base_x});
        dy = 21'(b_s) - 21'({3'd0, base_y});

        // Odd rotations swap the diamond axes.
        if (i_cfg.rotation[0]) begin
            u = -22'(dx) - 22'(dy);
            v = 22'(dx) - 22'(dy);
        end else begin
            u = 22'(dx) - 22'(dy);
            v = 22'(dx) + 22'(dy);
        end
        um1     = 23'(u) - 23'sd1;
        px_full = 28'(um1) <<< xsh;
        py_full = 26'(v) <<< ysh;
        h5      = 19'(h_s) * 19'(LIFT_BASE);
        hg      = 21'(h5) <<< z;

        pxs = fine ? trunc_shr(32'(px_full), FINE_SHIFT) : 32'(px_full);
        pys = fine ? trunc_shr(32'(py_full), FINE_SHIFT) : 32'(py_full);
        hs  = fine ? trunc_shr(32'(hg), FINE_SHIFT) : 32'(hg);
        sv  = neg ? -32'(v) : 32'(v);

        // Screen back to tile.
        t1 = trunc_shr(32'(a_s) - cw, {1'b0, xsh});
        t2 = trunc_shr(32'(b_s) - ch, {1'b0, ysh});
        t3 = trunc_shr(t2 - t1 + 32'sd1, 4'd1);
        tt = t1 + t3;
        unique case (i_cfg.rotation)
            2'd0: begin
                ra = tt;
                rb = t3;
            end
            2'd1: begin
                ra = t3;
                rb = -tt;
            end
            2'd2: begin
                ra = -tt;
                rb = -t3;
            end
            default: begin
                ra = -t3;
                rb = tt;
            end
        endcase

        unique case (i_item.func)
            FUNC_TILE, FUNC_FINE: begin
                o_item.out_a     = cw + (neg ? -pxs : pxs);
                o_item.out_b     = ch + (neg ? -pys : pys) - hs;
                o_item.depth_key = fine ? sv : (sv <<< FINE_SHIFT);
            end
            FUNC_SCREEN: begin
                o_item.out_a     = ra + cx;
                o_item.out_b     = rb + cy;
                o_item.depth_key = 32'sd0;
            end
            default: begin
                o_item.out_a     = 32'sd0;
                o_item.out_b     = 32'sd0;
                o_item.depth_key = 32'sd0;
            end
        endcase
    end

endmodule

### hdl/isometric_tile_projection.sv
// Top level of the isometric tile projection block: handshake, registers, config.
//
// Converts map tile coordinates to screen pixels of a 2:1 isometric view, from
// whole tiles (func 0) or 1/256-tile fine coordinates (func 1), and maps a
// screen point back to a map tile (func 2). Each input transfer yields exactly
// one result transfer, in order.
// The input channel (i_in_valid / o_in_ready / i_in_item) feeds an input
// register; one short combinational pass through itp_core feeds the result
// register that drives the output channel (o_out_valid / i_out_ready /
// o_out_item). An item accepted into the input register is loaded into the
// result register and presented there, and its result transfer completes
// when the receiver takes it. While the receiver does not stall, a new item
// can be accepted in every cycle, so the sustained rate is one item per cycle.
// When the receiver stalls, the result register holds its transfer, the input
// register takes one more item only if it is empty, and then o_in_ready drops
// until the receiver takes the result; no item is lost or repeated.
// The configuration port writes one register per cycle with i_cfg_we; the
// registers must only be changed while no item is in flight.
// A synchronous active-low reset empties both registers and loads the view
// registers with their defaults (640x480 screen, camera at the map center,
// no rotation, zoom level 1).
module isometric_tile_projection
    import itp_pkg::*;
#(
    parameter int MAP_WIDTH  = 512,
    parameter int MAP_HEIGHT = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    // The camera resets to the map center, kept to the register width.
    localparam logic [8:0] CamXReset = 9'(MAP_WIDTH / 2);
    localparam logic [8:0] CamYReset = 9'(MAP_HEIGHT / 2);

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      out_free;
    logic      advance;

    // The result register can load when it is empty or its transfer completes.
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    itp_core u_core (
        .i_cfg  (r_cfg),
        .i_item (r_in),
        .o_item (n_out)
    );

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_cfg.screen_width  <= SCREEN_WIDTH_RESET;
            r_cfg.screen_height <= SCREEN_HEIGHT_RESET;
            r_cfg.camera_x      <= CamXReset;
            r_cfg.camera_y      <= CamYReset;
            r_cfg.rotation      <= ROTATION_RESET;
            r_cfg.zoom          <= ZOOM_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data;
                    REG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data;
                    REG_CAMERA_X:      r_cfg.camera_x      <= i_cfg_data[8:0];
                    REG_CAMERA_Y:      r_cfg.camera_y      <= i_cfg_data[8:0];
                    REG_ROTATION:      r_cfg.rotation      <= i_cfg_data[1:0];
                    REG_ZOOM:          r_cfg.zoom          <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers load only on a transfer into their stage.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
